FILE: hdl/axis_angle_camera_rotate_defines.svh
// assertion macros for the axis-angle camera rotator
`ifndef AXIS_ANGLE_CAMERA_ROTATE_DEFINES_SVH
`define AXIS_ANGLE_CAMERA_ROTATE_DEFINES_SVH

// same-cycle implication, clocked on clk, off while in reset
`define ACR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while in reset
`define ACR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/acr_pkg.sv
// shared constants and tables for the axis-angle camera rotator
package acr_pkg;

  localparam int VEC_W       = 32;
  localparam int DEG_W       = 26;
  localparam int IN_TDATA_W  = 224;
  localparam int OUT_TDATA_W = 192;
  localparam int ROOT_STEPS  = 32;
  localparam int MAX_CORDIC  = 24;

  // cordic gain 0.6072529350 in q30
  localparam longint GAIN_Q30 = 64'sd652032874;

  // atan(2^-i) in degrees, 24 fraction bits
  localparam longint ATAN_Q24 [MAX_CORDIC] = '{
    754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  // table entry rounded to fb fraction bits
  function automatic longint atan_q(input int i, input int fb);
    longint v;
    v = ATAN_Q24[i];
    if (fb >= 24) begin
      return v;
    end
    return (v + (64'sd1 <<< (23 - fb))) >>> (24 - fb);
  endfunction

endpackage

FILE: hdl/axis_angle_camera_rotate.sv
// axis-angle (rodrigues) rotation of camera eye and up vectors, deep pipeline
//
//  channel | ports                     | beat contents
//  --------+---------------------------+------------------------------------------
//  in      | in_tvalid/tready/tdata/tuser | tuser: action; tdata: angle, eye, up
//  out     | out_tvalid/tready/tdata/tuser| tuser: degenerate_axis; tdata: eye, up
//
//  one beat per cycle in and out while the output is not stalled
//  the depth is set by the 32-step square root, the FRAC_BITS+1 step divider per
//  axis lane and the rotation multipliers; cordic runs alongside the axis path
//  reset clears the stage valid bits only
//  a stalled output holds its beat, empty stages keep filling behind it, so
//  in_tready only drops once every stage holds a beat
`include "axis_angle_camera_rotate_defines.svh"

module axis_angle_camera_rotate #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // turn_degrees[25:0], eye_x, eye_y, eye_z, up_x, up_y, up_z (32 each), zero pad
  input  logic [acr_pkg::IN_TDATA_W-1:0]     in_tdata,
  // action
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // new_eye_x, new_eye_y, new_eye_z, new_up_x, new_up_y, new_up_z (32 each)
  output logic [acr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // degenerate_axis
  output logic                               out_tuser
);
  import acr_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int AW = (F + 10 > 27) ? F + 10 : 27;  // angle word
  localparam int CW = F + 3;                         // cordic x/y word
  localparam int NW = F + 33;                        // divider remainder
  localparam int CS = (CORDIC_STEPS < MAX_CORDIC) ? CORDIC_STEPS : MAX_CORDIC;

  localparam longint FULL    = 64'sd360 <<< F;
  localparam longint RATIO   = (64'sd1 <<< 25) / FULL;
  localparam int     RED_N   = $clog2(RATIO) + 1;
  localparam longint GAIN    = (GAIN_Q30 + (64'sd1 <<< (29 - F))) >>> (30 - F);

  localparam logic signed [AW-1:0] FULL_S  = AW'(FULL);
  localparam logic signed [AW-1:0] HALF_S  = AW'(64'sd180 <<< F);
  localparam logic signed [AW-1:0] QUART_S = AW'(64'sd90 <<< F);
  localparam logic signed [CW:0]   ONE_C   = (CW + 1)'(64'sd1 <<< F);
  localparam logic [F:0]           ONE_Q   = (F + 1)'(64'd1 << F);

  // axis path schedule
  localparam int S_MUL  = 1;
  localparam int S_CRS  = 2;
  localparam int S_LZ   = 3;
  localparam int S_SH   = 4;
  localparam int S_SQ   = 5;
  localparam int S_SUM  = 6;
  localparam int S_RT   = 7;
  localparam int S_DSET = S_RT + ROOT_STEPS;
  localparam int S_DV   = S_DSET + 1;
  localparam int S_NRM  = S_DV + F + 1;
  localparam int S_R1   = S_NRM + 1;
  localparam int S_R2   = S_R1 + 1;
  localparam int S_R3   = S_R2 + 1;
  localparam int S_R4   = S_R3 + 1;
  localparam int S_R5   = S_R4 + 1;
  localparam int LAST   = S_R5 + 1;

  // angle path schedule, runs inside the axis path stages
  localparam int S_A0  = 1;
  localparam int S_RED = 2;
  localparam int S_AF  = S_RED + RED_N;
  localparam int S_CD  = S_AF + 1;
  localparam int S_AN  = S_CD + CS;

  typedef struct {
    logic                act;
    logic signed [31:0]  eye [3];
    logic signed [31:0]  up [3];
    logic                dsg;
    logic                neg;
    logic signed [AW-1:0] ang;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [63:0]  pr [6];
    logic                sgn [3];
    logic [62:0]         mag [3];
    logic [5:0]          lead;
    logic                degen;
    logic [30:0]         nm [3];
    logic [61:0]         sq [3];
    logic [63:0]         sn;
    logic [63:0]         sr;
    logic [31:0]         len;
    logic [NW-1:0]       rem [3];
    logic [F:0]          q [3];
    logic signed [F+1:0] nv [3];
    logic signed [63:0]  m [2][3][3];
    logic signed [35:0]  cr [2][3];
    logic signed [35:0]  dot [2];
    logic signed [63:0]  cv [2][3];
    logic signed [63:0]  scr [2][3];
    logic signed [63:0]  km [2];
    logic signed [38:0]  k [2];
    logic signed [63:0]  kn [2][3];
    logic [31:0]         res [2][3];
  } stage_t;

  function automatic logic signed [63:0] rnd(input logic signed [63:0] x);
    return (x + (64'sd1 <<< (F - 1))) >>> F;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'h7fff_ffff;
    end
    if (x < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return x[31:0];
  endfunction

  stage_t     st_r   [LAST+1];
  stage_t     st_nxt [LAST+1];
  logic [LAST:0] v_r;
  logic [LAST:0] rdy;

  // a stage takes a beat when it is empty or its successor moves
  assign rdy[LAST] = !v_r[LAST] || out_tready;
  for (genvar s = 0; s < LAST; s++) begin : g_rdy
    assign rdy[s] = !v_r[s] || rdy[s+1];
  end

  assign in_tready = rdy[0];

  // input register
  always_comb begin
    st_nxt[0] = st_r[0];
    st_nxt[0].act = in_tuser;
    st_nxt[0].ang = AW'($signed(in_tdata[25:0]));
    for (int j = 0; j < 3; j++) begin
      st_nxt[0].eye[j] = $signed(in_tdata[26 + 32*j +: 32]);
      st_nxt[0].up[j]  = $signed(in_tdata[122 + 32*j +: 32]);
    end
  end

  for (genvar s = 1; s <= LAST; s++) begin : g_st
    always_comb begin
      stage_t cur;
      stage_t nx;
      logic [62:0] orv;
      logic signed [63:0] ax [3];
      logic signed [AW-1:0] r;
      logic signed [CW:0] om;
      logic signed [31:0] v [2][3];
      logic [63:0] bt;
      logic [63:0] tr;
      logic signed [63:0] t;
      cur = st_r[s-1];
      nx  = cur;
      orv = '0;
      r   = '0;
      om  = '0;
      bt  = '0;
      tr  = '0;
      t   = '0;
      for (int j = 0; j < 3; j++) begin
        ax[j]   = '0;
        v[0][j] = cur.eye[j];
        v[1][j] = cur.up[j];
      end

      // ---------------- angle path ----------------
      if (s == S_A0) begin
        nx.dsg = cur.ang < 0;
        nx.ang = (cur.ang < 0) ? -cur.ang : cur.ang;
      end
      if (s >= S_RED && s < S_RED + RED_N) begin
        // magnitude mod 360, one multiple of 360 * 2^k per stage
        if (64'(cur.ang) >= (64'(FULL) << (RED_N - 1 - (s - S_RED)))) begin
          nx.ang = cur.ang - AW'(64'(FULL) << (RED_N - 1 - (s - S_RED)));
        end
      end
      if (s == S_AF) begin
        r = cur.dsg ? -cur.ang : cur.ang;
        if (r > HALF_S) begin
          r = r - FULL_S;
        end else if (r < -HALF_S) begin
          r = r + FULL_S;
        end
        nx.neg = 1'b0;
        if (r > QUART_S) begin
          r = r - HALF_S;
          nx.neg = 1'b1;
        end else if (r < -QUART_S) begin
          r = r + HALF_S;
          nx.neg = 1'b1;
        end
        nx.ang = r;
        nx.cx  = CW'(GAIN);
        nx.cy  = '0;
      end
      if (s >= S_CD && s < S_CD + CS) begin
        if (cur.ang >= 0) begin
          nx.cx  = cur.cx - (cur.cy >>> (s - S_CD));
          nx.cy  = cur.cy + (cur.cx >>> (s - S_CD));
          nx.ang = cur.ang - AW'(atan_q(s - S_CD, F));
        end else begin
          nx.cx  = cur.cx + (cur.cy >>> (s - S_CD));
          nx.cy  = cur.cy - (cur.cx >>> (s - S_CD));
          nx.ang = cur.ang + AW'(atan_q(s - S_CD, F));
        end
      end
      if (s == S_AN) begin
        // folded angles flip both sine and cosine
        if (cur.neg) begin
          nx.cx = -cur.cx;
          nx.cy = -cur.cy;
        end
      end

      // ---------------- axis path ----------------
      if (s == S_MUL) begin
        nx.pr[0] = cur.eye[1] * cur.up[2];
        nx.pr[1] = cur.eye[2] * cur.up[1];
        nx.pr[2] = cur.eye[2] * cur.up[0];
        nx.pr[3] = cur.eye[0] * cur.up[2];
        nx.pr[4] = cur.eye[0] * cur.up[1];
        nx.pr[5] = cur.eye[1] * cur.up[0];
      end
      if (s == S_CRS) begin
        if (cur.act) begin
          ax[0] = cur.pr[0] - cur.pr[1];
          ax[1] = cur.pr[2] - cur.pr[3];
          ax[2] = cur.pr[4] - cur.pr[5];
        end else begin
          for (int j = 0; j < 3; j++) begin
            ax[j] = 64'(cur.up[j]);
          end
        end
        for (int j = 0; j < 3; j++) begin
          nx.sgn[j] = ax[j] < 0;
          nx.mag[j] = 63'((ax[j] < 0) ? -ax[j] : ax[j]);
        end
      end
      if (s == S_LZ) begin
        // leading one of the largest magnitude equals that of the or
        orv = cur.mag[0] | cur.mag[1] | cur.mag[2];
        nx.lead  = '0;
        nx.degen = (orv == '0);
        for (int j = 0; j < 63; j++) begin
          if (orv[j]) begin
            nx.lead = 6'(j);
          end
        end
      end
      if (s == S_SH) begin
        for (int j = 0; j < 3; j++) begin
          if (cur.lead >= 6'd30) begin
            nx.nm[j] = 31'(cur.mag[j] >> (cur.lead - 6'd30));
          end else begin
            nx.nm[j] = 31'(cur.mag[j] << (6'd30 - cur.lead));
          end
        end
      end
      if (s == S_SQ) begin
        for (int j = 0; j < 3; j++) begin
          nx.sq[j] = 62'(cur.nm[j]) * 62'(cur.nm[j]);
        end
      end
      if (s == S_SUM) begin
        nx.sn = 64'(cur.sq[0]) + 64'(cur.sq[1]) + 64'(cur.sq[2]);
        nx.sr = '0;
      end
      if (s >= S_RT && s < S_RT + ROOT_STEPS) begin
        // restoring square root, one result bit per stage
        bt = 64'd1 << (62 - 2 * (s - S_RT));
        tr = cur.sr + bt;
        if (cur.sn >= tr) begin
          nx.sn = cur.sn - tr;
          nx.sr = (cur.sr >> 1) + bt;
        end else begin
          nx.sr = cur.sr >> 1;
        end
      end
      if (s == S_DSET) begin
        nx.len = cur.sr[31:0];
        for (int j = 0; j < 3; j++) begin
          nx.rem[j] = NW'({cur.nm[j], {F{1'b0}}}) + NW'(cur.sr[31:1]);
          nx.q[j]   = '0;
        end
      end
      if (s >= S_DV && s < S_DV + F + 1) begin
        // restoring divide, three lanes, quotient bit F down to 0
        for (int j = 0; j < 3; j++) begin
          if (cur.rem[j] >= (NW'(cur.len) << (F - (s - S_DV)))) begin
            nx.rem[j] = cur.rem[j] - (NW'(cur.len) << (F - (s - S_DV)));
            nx.q[j][F - (s - S_DV)] = 1'b1;
          end
        end
      end
      if (s == S_NRM) begin
        for (int j = 0; j < 3; j++) begin
          nx.nv[j] = cur.sgn[j] ? -$signed({1'b0, cur.q[j]}) : $signed({1'b0, cur.q[j]});
        end
      end

      // ---------------- rotation, eye and up lanes ----------------
      if (s == S_R1) begin
        for (int w = 0; w < 2; w++) begin
          for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
              nx.m[w][i][j] = cur.nv[i] * v[w][j];
            end
          end
        end
      end
      if (s == S_R2) begin
        for (int w = 0; w < 2; w++) begin
          nx.cr[w][0] = 36'(rnd(cur.m[w][1][2] - cur.m[w][2][1]));
          nx.cr[w][1] = 36'(rnd(cur.m[w][2][0] - cur.m[w][0][2]));
          nx.cr[w][2] = 36'(rnd(cur.m[w][0][1] - cur.m[w][1][0]));
          nx.dot[w]   = 36'(rnd(cur.m[w][0][0] + cur.m[w][1][1] + cur.m[w][2][2]));
        end
      end
      if (s == S_R3) begin
        om = ONE_C - cur.cx;
        for (int w = 0; w < 2; w++) begin
          nx.km[w] = om * cur.dot[w];
          for (int j = 0; j < 3; j++) begin
            nx.cv[w][j]  = cur.cx * v[w][j];
            nx.scr[w][j] = cur.cy * cur.cr[w][j];
          end
        end
      end
      if (s == S_R4) begin
        for (int w = 0; w < 2; w++) begin
          nx.k[w] = 39'(rnd(cur.km[w]));
        end
      end
      if (s == S_R5) begin
        for (int w = 0; w < 2; w++) begin
          for (int j = 0; j < 3; j++) begin
            nx.kn[w][j] = cur.k[w] * cur.nv[j];
          end
        end
      end
      if (s == LAST) begin
        for (int j = 0; j < 3; j++) begin
          t = rnd(cur.cv[0][j] + cur.scr[0][j] + cur.kn[0][j]);
          nx.res[0][j] = cur.degen ? cur.eye[j] : sat32(t);
          t = rnd(cur.cv[1][j] + cur.scr[1][j] + cur.kn[1][j]);
          nx.res[1][j] = (cur.degen || !cur.act) ? cur.up[j] : sat32(t);
        end
      end

      st_nxt[s] = nx;
    end
  end

  // valid bits travel with the payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int s = 1; s <= LAST; s++) begin
        if (rdy[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    for (int s = 0; s <= LAST; s++) begin
      if (rdy[s]) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  assign out_tvalid = v_r[LAST];
  assign out_tuser  = st_r[LAST].degen;
  assign out_tdata  = {st_r[LAST].res[1][2], st_r[LAST].res[1][1], st_r[LAST].res[1][0],
                       st_r[LAST].res[0][2], st_r[LAST].res[0][1], st_r[LAST].res[0][0]};

  // back-pressure reaches the input only with every stage occupied
  `ACR_ASSERT_SAME(a_full_when_blocked, !in_tready, &v_r, "input blocked with a free stage")
  // a full pipeline with a stalled output stays full
  `ACR_ASSERT_NEXT(a_full_holds, !in_tready && !out_tready, &v_r, "full pipeline drained")
  // normalized axis length lies in [2^30, 2^32)
  `ACR_ASSERT_SAME(a_len_range, v_r[S_DSET] && !st_r[S_DSET].degen,
                   st_r[S_DSET].len[31:30] != 2'b00, "axis length below range")
  // unit axis components never exceed one
  `ACR_ASSERT_SAME(a_unit_bound, v_r[S_NRM] && !st_r[S_NRM].degen,
                   st_r[S_NRM].q[0] <= ONE_Q && st_r[S_NRM].q[1] <= ONE_Q &&
                   st_r[S_NRM].q[2] <= ONE_Q, "unit axis component above one")

endmodule

FILE: bench/acr_checker.sv
// scoreboard for the axis-angle camera rotator: predicts each output beat and compares
module acr_checker #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [acr_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [acr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            out_tuser,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] vec [6];
    logic        degen;
  } rotated_pair_t;

  rotated_pair_t rotated_q [$];

  function automatic longint round_q(input longint v, input int s);
    if (s == 0) begin
      return v;
    end
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic void angle_sin_cos(input longint deg, output longint s,
                                        output longint c);
    longint full, half, quarter, r, x, y, dx, dy, at;
    bit     flip;
    full    = 64'sd360 <<< FRAC_BITS;
    half    = 64'sd180 <<< FRAC_BITS;
    quarter = 64'sd90 <<< FRAC_BITS;
    flip    = 0;
    r = deg % full;
    if (r > half) r -= full;
    if (r < -half) r += full;
    // fold into +-90 and flip both outputs
    if (r > quarter) begin
      r -= half;
      flip = 1;
    end else if (r < -quarter) begin
      r += half;
      flip = 1;
    end
    x = (acr_pkg::GAIN_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      at = round_q(acr_pkg::ATAN_Q24[i], 24 - FRAC_BITS);
      dx = y >>> i;
      dy = x >>> i;
      if (r >= 0) begin
        x -= dx; y += dy; r -= at;
      end else begin
        x += dx; y -= dy; r += at;
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // false for an all-zero axis
  function automatic bit normalize_axis(input longint a [3], output longint n [3]);
    longint unsigned mag [3];
    longint unsigned top, sq, len, q;
    top = 0;
    sq  = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = (a[k] < 0) ? 64'd0 - longint'(a[k]) : a[k];
      if (mag[k] > top) top = mag[k];
    end
    if (top == 0) begin
      return 0;
    end
    while (top < (64'd1 << 30)) begin
      top <<= 1;
      for (int k = 0; k < 3; k++) mag[k] <<= 1;
    end
    while (top >= (64'd1 << 31)) begin
      top >>= 1;
      for (int k = 0; k < 3; k++) mag[k] >>= 1;
    end
    for (int k = 0; k < 3; k++) sq += mag[k] * mag[k];
    len = int_sqrt(sq);
    for (int k = 0; k < 3; k++) begin
      q = ((mag[k] << FRAC_BITS) + (len >> 1)) / len;
      n[k] = (a[k] < 0) ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic logic [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic void rodrigues(input longint n [3], input longint s, input longint c,
                                    input longint v [3], output logic [31:0] r [3]);
    longint cr [3];
    longint dot, kk;
    cr[0] = round_q(n[1] * v[2] - n[2] * v[1], FRAC_BITS);
    cr[1] = round_q(n[2] * v[0] - n[0] * v[2], FRAC_BITS);
    cr[2] = round_q(n[0] * v[1] - n[1] * v[0], FRAC_BITS);
    dot = round_q(n[0] * v[0] + n[1] * v[1] + n[2] * v[2], FRAC_BITS);
    kk  = round_q(((64'sd1 <<< FRAC_BITS) - c) * dot, FRAC_BITS);
    for (int i = 0; i < 3; i++) begin
      r[i] = sat32(round_q(c * v[i] + s * cr[i] + kk * n[i], FRAC_BITS));
    end
  endfunction

  function automatic rotated_pair_t predict_rotation(input logic act,
                                                     input logic [acr_pkg::IN_TDATA_W-1:0] d);
    rotated_pair_t res;
    longint eye [3], up [3], axis [3], n [3];
    longint s, c, deg;
    logic [31:0] r [3];
    deg = longint'($signed(d[25:0]));
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(d[26 + 32*i +: 32]));
      up[i]  = longint'($signed(d[122 + 32*i +: 32]));
      res.vec[i]     = d[26 + 32*i +: 32];
      res.vec[3 + i] = d[122 + 32*i +: 32];
    end
    if (act == 1'b0) begin
      axis = up;
    end else begin
      axis[0] = eye[1] * up[2] - eye[2] * up[1];
      axis[1] = eye[2] * up[0] - eye[0] * up[2];
      axis[2] = eye[0] * up[1] - eye[1] * up[0];
    end
    res.degen = 1'b1;
    if (normalize_axis(axis, n)) begin
      res.degen = 1'b0;
      angle_sin_cos(deg, s, c);
      rodrigues(n, s, c, eye, r);
      for (int i = 0; i < 3; i++) res.vec[i] = r[i];
      if (act == 1'b1) begin
        rodrigues(n, s, c, up, r);
        for (int i = 0; i < 3; i++) res.vec[3 + i] = r[i];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    rotated_pair_t exp_beat;
    int            errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
      pending    <= 0;
      rotated_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        rotated_q.push_back(predict_rotation(in_tuser, in_tdata));
      end
      if (out_tvalid && out_tready) begin
        if (rotated_q.size() == 0) begin
          $display("%0t: unexpected output beat %h user %b", $time, out_tdata, out_tuser);
          errs++;
        end else begin
          exp_beat = rotated_q.pop_front();
          for (int i = 0; i < 6; i++) begin
            if (out_tdata[32*i +: 32] !== exp_beat.vec[i]) begin
              $display("%0t: field %0d expected %h actual %h", $time, i,
                       exp_beat.vec[i], out_tdata[32*i +: 32]);
              errs++;
            end
          end
          if (out_tuser !== exp_beat.degen) begin
            $display("%0t: degenerate_axis expected %b actual %b", $time,
                     exp_beat.degen, out_tuser);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending    <= rotated_q.size();
    end
  end

endmodule

FILE: bench/axis_angle_camera_rotate_tb.sv
// stimulus, handshake pacing and verdict for the axis-angle camera rotator
module axis_angle_camera_rotate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  LATENCY   = 16 + 48;
  localparam int  N_RANDOM  = 750;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [acr_pkg::IN_TDATA_W-1:0] in_tdata = '0;   // turn, eye xyz, up xyz, pad
  logic in_tuser = 1'b0;                            // action
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [acr_pkg::OUT_TDATA_W-1:0] out_tdata;      // new eye xyz, new up xyz
  logic out_tuser;                                  // degenerate_axis
  int   fail_count, pending;
  longint cycles = 0;
  int   stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  axis_angle_camera_rotate uut (.*);

  acr_checker chk (.*);

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver stalls: mostly short, a few long, and calm stretches with none
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if ((cycles / 2000) % 3 != 2) begin
        case ($urandom_range(0, 99)) inside
          [0:24]:  stall_left <= $urandom_range(1, 3);
          [25:27]: stall_left <= $urandom_range(20, 80);
          default: stall_left <= 0;
        endcase
      end
    end
  end

  // present one beat and hold it until taken
  task automatic send(input logic act, input logic [25:0] deg,
                      input logic [31:0] ex, input logic [31:0] ey, input logic [31:0] ez,
                      input logic [31:0] ux, input logic [31:0] uy, input logic [31:0] uz);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {6'd0, uz, uy, ux, ez, ey, ex, deg};
    do @(posedge clk); while (!in_tready);
  endtask

  // sender gap after a beat
  task automatic sender_gap(input bit calm);
    int g;
    g = 0;
    if (!calm) begin
      case ($urandom_range(0, 99)) inside
        [0:29]:  g = $urandom_range(1, 3);
        [30:32]: g = $urandom_range(15, 60);
        default: g = 0;
      endcase
    end
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      1, 2, 3: return $urandom();
      4:       return 32'd0;
      default: return 32'($signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
    endcase
  endfunction

  function automatic logic [25:0] rand_turn();
    if ($urandom_range(0, 4) == 0) begin
      return 26'($urandom());
    end
    return 26'($signed($urandom_range(0, 47185920)) - 32'sd23592960);
  endfunction

  initial begin
    logic [31:0] e [3], u [3];
    logic        act;
    int          sel;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero axes under both actions
    send(1'b0, 26'(90 << 16), 32'h00010000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send(1'b1, 26'(45 << 16), 32'h00020000, 32'h00010000, 32'h0,
         32'h00020000, 32'h00010000, 32'h0);
    send(1'b1, 26'(30 << 16), 32'h0, 32'h0, 32'h0, 32'h0, 32'h00010000, 32'h0);
    // quarter, half and full turns, negative and folded angles
    send(1'b0, 26'(90 << 16), 32'h00010000, 32'h0, 32'h0, 32'h0, 32'h00010000, 32'h0);
    send(1'b0, 26'(-90 <<< 16), 32'h00010000, 32'h0, 32'h0, 32'h0, 32'h00010000, 32'h0);
    send(1'b0, 26'(180 << 16), 32'h00030000, 32'h0, 32'h00010000, 32'h0, 32'h00010000, 32'h0);
    send(1'b0, 26'(360 << 16), 32'h00030000, 32'h00020000, 32'h00010000,
         32'h0, 32'h0, 32'h00010000);
    send(1'b0, 26'(-360 <<< 16), 32'h00030000, 32'h00020000, 32'h00010000,
         32'h00010000, 32'h0, 32'h0);
    send(1'b1, 26'(135 << 16), 32'h0, 32'h0, 32'h00050000, 32'h0, 32'h00010000, 32'h0);
    send(1'b1, 26'(-135 <<< 16), 32'h0, 32'h0, 32'h00050000, 32'h00010000, 32'h00010000, 32'h0);
    send(1'b0, 26'd0, 32'h12345678, 32'hfedcba98, 32'h00abcdef, 32'h1, 32'h1, 32'h1);
    // angle field extremes
    send(1'b0, 26'h1ffffff, 32'h00010000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h00010000);
    send(1'b1, 26'h2000000, 32'h00010000, 32'h0, 32'h0, 32'h0, 32'h00010000, 32'h0);
    // vector extremes, saturation
    send(1'b0, 26'(45 << 16), 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
         32'h80000000, 32'h0, 32'h0);
    send(1'b1, 26'(60 << 16), 32'h80000000, 32'h7fffffff, 32'h80000000,
         32'h7fffffff, 32'h80000000, 32'h80000000);
    send(1'b1, 26'(-170 <<< 16), 32'h7fffffff, 32'h0, 32'h0, 32'h0, 32'h7fffffff, 32'h0);
    send(1'b0, 26'(1 << 16), 32'h80000000, 32'h80000000, 32'h80000000,
         32'h80000000, 32'h80000000, 32'h80000000);
    send(1'b1, 26'(1), 32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0);
    send(1'b0, 26'(89 << 16), 32'h00010000, 32'h0, 32'h0, 32'h0, 32'hffffffff, 32'h0);

    // random part: mostly sensible vectors, some parallel pairs and zero axes
    for (int n = 0; n < N_RANDOM; n++) begin
      act = 1'($urandom_range(0, 1));
      for (int i = 0; i < 3; i++) begin
        e[i] = rand_comp();
        u[i] = rand_comp();
      end
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        u = e;                                  // parallel, zero cross product
      end else if (sel == 1) begin
        for (int i = 0; i < 3; i++) u[i] = -e[i];
      end else if (sel == 2) begin
        u = '{32'd0, 32'd0, 32'd0};             // zero up
      end
      send(act, rand_turn(), e[0], e[1], e[2], u[0], u[1], u[2]);
      if (n == N_RANDOM / 2) begin
        // drain the pipe completely once
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end else begin
        sender_gap(n >= 300 && n < 400);
      end
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (LATENCY + 16) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: axis_angle_camera_rotate.f
+incdir+hdl
hdl/acr_pkg.sv
hdl/axis_angle_camera_rotate.sv
bench/acr_checker.sv
bench/axis_angle_camera_rotate_tb.sv
